// ===== design/point_to_pixel_projection_window_top_assert.svh =====
// Assertion macros for the projection window block.
// Used by point_to_pixel_projection_window_top; no other dependencies.
`ifndef POINT_TO_PIXEL_PROJECTION_WINDOW_TOP_ASSERT_SVH
`define POINT_TO_PIXEL_PROJECTION_WINDOW_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define PPW_ASSERT_NEVER(lbl, clk, rst_n, bad) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) !(bad)) \
        else $error("assertion failed: forbidden condition seen");
`define PPW_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle consequence missing");
`else
`define PPW_ASSERT_NEVER(lbl, clk, rst_n, bad)
`define PPW_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== design/ppw_pkg.sv =====
// Shared types and constants for the projection window block.
// No dependencies.
package ppw_pkg;
    localparam int COEF_W    = 18;
    localparam int POS_W     = 21;
    localparam int FOC_W     = 32;
    localparam int PIX_W     = 12;
    localparam int Q_FRAC    = 16;
    localparam int SPLIT     = 26;
    localparam int CFG_W     = 64;
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_ROT_X  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROT_Y  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ROT_Z  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CAM    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FOCAL  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_PRINC  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW = 3'd6;

    typedef struct packed {
        logic [3*COEF_W-1:0] rot_x;
        logic [3*COEF_W-1:0] rot_y;
        logic [3*COEF_W-1:0] rot_z;
        logic [3*POS_W-1:0]  cam;
        logic [2*FOC_W-1:0]  focal;
        logic [2*FOC_W-1:0]  princ;
        logic [4*PIX_W-1:0]  window;
    } t_cfg;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_st;
endpackage

// ===== design/ppw_front.sv =====
// Front end: camera offset, 3x3 rotation, depth test.
// Depends on ppw_pkg; feeds ppw_queue.
module ppw_front #(
    parameter int COORD_BITS = 24,
    parameter int W_D        = 25,
    parameter int W_C        = 45
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  ppw_pkg::t_cfg                i_cfg,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic signed [COORD_BITS-1:0] i_world_x,
    input  logic signed [COORD_BITS-1:0] i_world_y,
    input  logic signed [COORD_BITS-1:0] i_world_z,
    input  ppw_pkg::t_q_st               i_q_st,
    output logic                         o_push,
    output logic signed [W_C-1:0]        o_xc,
    output logic signed [W_C-1:0]        o_yc,
    output logic signed [W_C-1:0]        o_zc
);
    import ppw_pkg::*;

    localparam int W_P = W_D + COEF_W;

    logic                   r_v0, r_v1, r_v2;
    logic [2:0]             w_adv;
    logic                   w_keep;
    logic signed [W_D-1:0]  r_d [3];
    logic signed [W_P-1:0]  r_p [3][3];
    logic signed [W_C-1:0]  r_c [3];
    logic [3*COEF_W-1:0]    w_row [3];

    assign w_row[0] = i_cfg.rot_x;
    assign w_row[1] = i_cfg.rot_y;
    assign w_row[2] = i_cfg.rot_z;

    // depth must be strictly positive
    assign w_keep = !r_c[2][W_C-1] && (r_c[2] != '0);

    assign w_adv[2] = !r_v2 || !(w_keep && i_q_st.full);
    assign w_adv[1] = !r_v1 || w_adv[2];
    assign w_adv[0] = !r_v0 || w_adv[1];
    assign o_stall  = !w_adv[0];
    assign o_push   = r_v2 && w_keep && !i_q_st.full;
    assign o_xc     = r_c[0];
    assign o_yc     = r_c[1];
    assign o_zc     = r_c[2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (w_adv[0]) r_v0 <= i_valid;
            if (w_adv[1]) r_v1 <= r_v0;
            if (w_adv[2]) r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv[0]) begin
            r_d[0] <= W_D'(i_world_x) - W_D'($signed(i_cfg.cam[POS_W-1:0]));
            r_d[1] <= W_D'(i_world_y) - W_D'($signed(i_cfg.cam[2*POS_W-1:POS_W]));
            r_d[2] <= W_D'(i_world_z) - W_D'($signed(i_cfg.cam[3*POS_W-1:2*POS_W]));
        end
        if (w_adv[1]) begin
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    r_p[r][c] <= $signed(w_row[r][c*COEF_W +: COEF_W]) * r_d[c];
                end
            end
        end
        if (w_adv[2]) begin
            for (int r = 0; r < 3; r++) begin
                r_c[r] <= W_C'(r_p[r][0]) + W_C'(r_p[r][1]) + W_C'(r_p[r][2]);
            end
        end
    end
endmodule

// ===== design/ppw_queue.sv =====
// Small FIFO between the front and back ends.
// Depends on ppw_pkg.
module ppw_queue #(
    parameter int W          = 135,
    parameter int DEPTH_LOG2 = 2
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  logic [W-1:0]   i_data,
    input  logic           i_pop,
    output logic [W-1:0]   o_data,
    output ppw_pkg::t_q_st o_st
);
    import ppw_pkg::*;

    localparam int DEPTH = 1 << DEPTH_LOG2;

    logic [W-1:0]            r_slot [DEPTH];
    logic [DEPTH_LOG2-1:0]   r_wp, r_rp;
    logic [DEPTH_LOG2:0]     r_cnt;

    assign o_st.full  = (r_cnt == (DEPTH_LOG2+1)'(DEPTH));
    assign o_st.empty = (r_cnt == '0);
    assign o_data     = r_slot[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + 1'b1;
            if (i_pop)  r_rp <= r_rp + 1'b1;
            unique case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_slot[r_wp] <= i_data;
    end
endmodule

// ===== design/ppw_back.sv =====
// Back end: intrinsics, window test, pipelined divide and round-half-even.
// Depends on ppw_pkg; pulls from ppw_queue.
module ppw_back #(
    parameter int W_C = 45
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  ppw_pkg::t_cfg         i_cfg,
    input  ppw_pkg::t_q_st        i_q_st,
    input  logic signed [W_C-1:0] i_xc,
    input  logic signed [W_C-1:0] i_yc,
    input  logic signed [W_C-1:0] i_zc,
    output logic                  o_pop,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [ppw_pkg::PIX_W-1:0] o_pixel_col,
    output logic [ppw_pkg::PIX_W-1:0] o_pixel_row
);
    import ppw_pkg::*;

    localparam int W_N   = W_C + 34;
    localparam int W_PH  = W_C - SPLIT + FOC_W + 1;
    localparam int W_PL  = SPLIT + FOC_W;
    localparam int W_B   = W_C + PIX_W + 1;
    localparam int NDIV  = PIX_W;
    localparam int NSTG  = NDIV + 4;
    localparam int S_WIN = 2;
    localparam int S_OUT = NSTG - 1;

    logic [NSTG-1:0]        r_v;
    logic [NSTG-1:0]        w_adv;
    logic signed [W_C-1:0]  w_c [2];
    logic [FOC_W-1:0]       w_f [2];
    logic [FOC_W-1:0]       w_p [2];
    logic [PIX_W-1:0]       w_lo [2];
    logic [PIX_W-1:0]       w_hi [2];
    logic                   w_ok;

    // stage 0: partial products
    logic signed [W_PH-1:0] r_cfh [2];
    logic [W_PL-1:0]        r_cfl [2];
    logic signed [W_PH-1:0] r_zph [2];
    logic [W_PL-1:0]        r_zpl [2];
    logic signed [W_B-1:0]  r_zlo [2];
    logic signed [W_B-1:0]  r_zhi [2];
    logic signed [W_C-1:0]  r_z0;
    // stage 1: numerator and scaled bounds
    logic signed [W_N-1:0]  r_n [2];
    logic signed [W_N-1:0]  r_bl [2];
    logic signed [W_N-1:0]  r_bh [2];
    logic signed [W_C-1:0]  r_z1;
    // stage 2: remainder seed
    logic signed [W_N-1:0]  r_rem2 [2];
    logic signed [W_C-1:0]  r_z2;
    // divide stages
    logic signed [W_N-1:0]  r_rem [NDIV][2];
    logic [PIX_W-1:0]       r_q   [NDIV][2];
    logic signed [W_C-1:0]  r_zd  [NDIV];
    logic signed [W_N-1:0]  w_rem_in [NDIV][2];
    logic [PIX_W-1:0]       w_q_in   [NDIV][2];
    logic signed [W_C-1:0]  w_z_in   [NDIV];
    logic signed [W_N-1:0]  w_dd     [NDIV];
    // rounding
    logic signed [W_N-1:0]  w_r2 [2];
    logic signed [W_N-1:0]  w_d16;
    logic [PIX_W-1:0]       w_pix [2];
    logic [PIX_W-1:0]       r_col, r_row;

    assign w_c[0] = i_xc;
    assign w_c[1] = i_yc;
    always_comb begin
        for (int a = 0; a < 2; a++) begin
            w_f[a]  = i_cfg.focal[a*FOC_W +: FOC_W];
            w_p[a]  = i_cfg.princ[a*FOC_W +: FOC_W];
            w_lo[a] = i_cfg.window[a*2*PIX_W +: PIX_W];
            w_hi[a] = i_cfg.window[a*2*PIX_W+PIX_W +: PIX_W];
        end
    end

    // advance chain, output register last
    always_comb begin
        w_adv[S_OUT] = !r_v[S_OUT] || !i_stall;
        for (int k = S_OUT - 1; k >= 0; k--) begin
            w_adv[k] = !r_v[k] || w_adv[k+1];
        end
    end
    assign o_pop   = w_adv[0] && !i_q_st.empty;
    assign o_valid = r_v[S_OUT];

    // strictly inside the window on both axes
    assign w_ok = (r_bl[0] < r_n[0]) && (r_n[0] < r_bh[0])
               && (r_bl[1] < r_n[1]) && (r_n[1] < r_bh[1]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            for (int k = 0; k < NSTG; k++) begin
                if (w_adv[k]) begin
                    if (k == 0)          r_v[k] <= !i_q_st.empty;
                    else if (k == S_WIN) r_v[k] <= r_v[k-1] && w_ok;
                    else                 r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv[0]) begin
            for (int a = 0; a < 2; a++) begin
                r_cfh[a] <= $signed(w_c[a][W_C-1:SPLIT]) * $signed({1'b0, w_f[a]});
                r_cfl[a] <= w_c[a][SPLIT-1:0] * w_f[a];
                r_zph[a] <= $signed(i_zc[W_C-1:SPLIT]) * $signed({1'b0, w_p[a]});
                r_zpl[a] <= i_zc[SPLIT-1:0] * w_p[a];
                r_zlo[a] <= i_zc * $signed({1'b0, w_lo[a]});
                r_zhi[a] <= i_zc * $signed({1'b0, w_hi[a]});
            end
            r_z0 <= i_zc;
        end
        if (w_adv[1]) begin
            for (int a = 0; a < 2; a++) begin
                r_n[a]  <= (W_N'(r_cfh[a]) <<< SPLIT) + W_N'(r_cfl[a])
                         + (W_N'(r_zph[a]) <<< SPLIT) + W_N'(r_zpl[a]);
                r_bl[a] <= W_N'(r_zlo[a]) <<< Q_FRAC;
                r_bh[a] <= W_N'(r_zhi[a]) <<< Q_FRAC;
            end
            r_z1 <= r_z0;
        end
        if (w_adv[S_WIN]) begin
            r_rem2 <= r_n;
            r_z2   <= r_z1;
        end
    end

    // one quotient bit per stage, most significant first
    always_comb begin
        for (int k = 0; k < NDIV; k++) begin
            if (k == 0) begin
                w_z_in[k] = r_z2;
                for (int a = 0; a < 2; a++) begin
                    w_rem_in[k][a] = r_rem2[a];
                    w_q_in[k][a]   = '0;
                end
            end else begin
                w_z_in[k] = r_zd[k-1];
                for (int a = 0; a < 2; a++) begin
                    w_rem_in[k][a] = r_rem[k-1][a];
                    w_q_in[k][a]   = r_q[k-1][a];
                end
            end
            w_dd[k] = W_N'(w_z_in[k]) <<< (Q_FRAC + NDIV - 1 - k);
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < NDIV; k++) begin
            if (w_adv[S_WIN+1+k]) begin
                r_zd[k] <= w_z_in[k];
                for (int a = 0; a < 2; a++) begin
                    if (w_rem_in[k][a] >= w_dd[k]) begin
                        r_rem[k][a] <= w_rem_in[k][a] - w_dd[k];
                        r_q[k][a]   <= w_q_in[k][a] | (PIX_W'(1) << (NDIV - 1 - k));
                    end else begin
                        r_rem[k][a] <= w_rem_in[k][a];
                        r_q[k][a]   <= w_q_in[k][a];
                    end
                end
            end
        end
    end

    // round to nearest, ties to even
    assign w_d16 = W_N'(r_zd[NDIV-1]) <<< Q_FRAC;
    always_comb begin
        for (int a = 0; a < 2; a++) begin
            w_r2[a]  = r_rem[NDIV-1][a] <<< 1;
            w_pix[a] = r_q[NDIV-1][a]
                     + PIX_W'(w_r2[a] > w_d16)
                     + PIX_W'((w_r2[a] == w_d16) && r_q[NDIV-1][a][0]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv[S_OUT]) begin
            r_col <= w_pix[0];
            r_row <= w_pix[1];
        end
    end

    assign o_pixel_col = r_col;
    assign o_pixel_row = r_row;
endmodule

// ===== design/point_to_pixel_projection_window_top.sv =====
// Top level of the pinhole projection window block.
// Depends on ppw_pkg, ppw_front, ppw_queue, ppw_back and the assertion header.
//
// Projects one world point per clock into pixel coordinates when neither
// side stalls. Each point has the camera position removed, is rotated into
// the camera frame by the configured 3x3 matrix, and is dropped when its
// depth is not positive. The rest get u = cx + fx*xc/zc and v = cy + fy*yc/zc
// computed exactly; a pixel is sent only when both lie strictly inside the
// crop window, rounded to nearest with ties to even. Throughput is one point
// per cycle while no stall holds the pipeline: every multiply and every
// quotient bit has its own pipeline stage. The front end registers the offset,
// the products and the sums; points then pass through the 4-entry queue; the
// back end registers partial products, numerator, window test, 12 divide
// stages and rounding into the output register. Dropped points produce no
// request; they only leave an empty pipeline slot behind them and never stall
// the input. Write the configuration only while the block is idle.
`include "point_to_pixel_projection_window_top_assert.svh"
module point_to_pixel_projection_window_top #(
    parameter int COORD_BITS = 24
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [ppw_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [ppw_pkg::CFG_W-1:0]          i_cfg_data,
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic signed [COORD_BITS-1:0]       i_world_x,
    input  logic signed [COORD_BITS-1:0]       i_world_y,
    input  logic signed [COORD_BITS-1:0]       i_world_z,
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic [ppw_pkg::PIX_W-1:0]          o_pixel_col,
    output logic [ppw_pkg::PIX_W-1:0]          o_pixel_row
);
    import ppw_pkg::*;

    // difference of input and camera position, then rotated sum
    localparam int W_D = ((COORD_BITS > POS_W) ? COORD_BITS : POS_W) + 1;
    localparam int W_C = W_D + COEF_W + 2;

    t_cfg                  r_cfg;
    t_q_st                 w_q_st;
    logic                  w_push, w_pop;
    logic signed [W_C-1:0] w_xc, w_yc, w_zc;
    logic [3*W_C-1:0]      w_q_out;

    // hold configuration; ignore writes past the last register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_ROT_X:  r_cfg.rot_x  <= i_cfg_data[3*COEF_W-1:0];
                CFG_ROT_Y:  r_cfg.rot_y  <= i_cfg_data[3*COEF_W-1:0];
                CFG_ROT_Z:  r_cfg.rot_z  <= i_cfg_data[3*COEF_W-1:0];
                CFG_CAM:    r_cfg.cam    <= i_cfg_data[3*POS_W-1:0];
                CFG_FOCAL:  r_cfg.focal  <= i_cfg_data;
                CFG_PRINC:  r_cfg.princ  <= i_cfg_data;
                CFG_WINDOW: r_cfg.window <= i_cfg_data[4*PIX_W-1:0];
                default:    r_cfg        <= r_cfg;
            endcase
        end
    end

    ppw_front #(
        .COORD_BITS (COORD_BITS),
        .W_D        (W_D),
        .W_C        (W_C)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_valid   (i_valid),
        .o_stall   (o_stall),
        .i_world_x (i_world_x),
        .i_world_y (i_world_y),
        .i_world_z (i_world_z),
        .i_q_st    (w_q_st),
        .o_push    (w_push),
        .o_xc      (w_xc),
        .o_yc      (w_yc),
        .o_zc      (w_zc)
    );

    ppw_queue #(
        .W          (3 * W_C),
        .DEPTH_LOG2 (2)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  ({w_zc, w_yc, w_xc}),
        .i_pop   (w_pop),
        .o_data  (w_q_out),
        .o_st    (w_q_st)
    );

    ppw_back #(
        .W_C (W_C)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_q_st      (w_q_st),
        .i_xc        (w_q_out[W_C-1:0]),
        .i_yc        (w_q_out[2*W_C-1:W_C]),
        .i_zc        (w_q_out[3*W_C-1:2*W_C]),
        .o_pop       (w_pop),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_pixel_col (o_pixel_col),
        .o_pixel_row (o_pixel_row)
    );

    // front end never pushes into a full queue
    `PPW_ASSERT_NEVER(a_no_overflow, i_clk, i_rst_n, w_push && w_q_st.full)
    // queue level is never both full and empty
    `PPW_ASSERT_NEVER(a_q_level, i_clk, i_rst_n, w_q_st.full && w_q_st.empty)
    // back end never pops an empty queue
    `PPW_ASSERT_NEVER(a_no_underflow, i_clk, i_rst_n, w_pop && w_q_st.empty)
    // reset drains the output register
    `PPW_ASSERT_NEXT(a_rst_out, i_clk, 1'b1, !i_rst_n, !o_valid)
endmodule

// ===== dv/testbench.sv =====
// Self-checking testbench for point_to_pixel_projection_window_top.
// Depends on ppw_pkg and the block's RTL; a scoreboard class predicts each pixel.
import ppw_pkg::*;

typedef logic signed [127:0] t_wide;

typedef struct {
    logic [PIX_W-1:0] col;
    logic [PIX_W-1:0] row;
} t_pixel;

class pixel_scoreboard;
    logic [CFG_W-1:0] regs [7];
    t_pixel           pending_pixels [$];
    int               mismatches;
    int               pixels_seen;
    int               points_seen;

    function new();
        foreach (regs[i]) regs[i] = '0;
        mismatches  = 0;
        pixels_seen = 0;
        points_seen = 0;
    endfunction

    // Mirror a register write, masked to the register width.
    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        case (idx)
            CFG_ROT_X, CFG_ROT_Y, CFG_ROT_Z: regs[idx] = val & ((64'd1 << 54) - 1);
            CFG_CAM:                         regs[idx] = val & ((64'd1 << 63) - 1);
            CFG_FOCAL, CFG_PRINC:            regs[idx] = val;
            CFG_WINDOW:                      regs[idx] = val & ((64'd1 << 48) - 1);
            default: ;
        endcase
    endfunction

    function t_wide coef(logic [CFG_W-1:0] row, int slot);
        logic signed [COEF_W-1:0] c;
        c = row[slot*COEF_W +: COEF_W];
        return t_wide'(c);
    endfunction

    function t_wide rotate(logic [CFG_W-1:0] row, t_wide dx, t_wide dy, t_wide dz);
        return coef(row, 0) * dx + coef(row, 1) * dy + coef(row, 2) * dz;
    endfunction

    // Exact u = p + f*c/zc; inside test, then round half to even.
    function bit map_axis(t_wide c, t_wide zc, logic [31:0] f, logic [31:0] p,
                          logic [11:0] lo, logic [11:0] hi, output logic [11:0] pix);
        t_wide fw, pw, num, den, q, r;
        fw  = {96'd0, f};
        pw  = {96'd0, p};
        num = c * fw + zc * pw;
        den = zc <<< Q_FRAC;
        pix = '0;
        if (!(den * t_wide'({116'd0, lo}) < num && num < den * t_wide'({116'd0, hi})))
            return 0;
        q = num / den;
        r = num - q * den;
        if (2 * r > den)
            q = q + 1;
        else if (2 * r == den && q[0])
            q = q + 1;
        pix = q[11:0];
        return 1;
    endfunction

    function void note_point(logic signed [23:0] x, logic signed [23:0] y,
                             logic signed [23:0] z);
        logic signed [POS_W-1:0] px, py, pz;
        t_wide  dx, dy, dz, xc, yc, zc;
        t_pixel pix;
        points_seen++;
        px = regs[CFG_CAM][20:0];
        py = regs[CFG_CAM][41:21];
        pz = regs[CFG_CAM][62:42];
        dx = t_wide'(x) - t_wide'(px);
        dy = t_wide'(y) - t_wide'(py);
        dz = t_wide'(z) - t_wide'(pz);
        xc = rotate(regs[CFG_ROT_X], dx, dy, dz);
        yc = rotate(regs[CFG_ROT_Y], dx, dy, dz);
        zc = rotate(regs[CFG_ROT_Z], dx, dy, dz);
        if (zc <= 0) return;
        if (!map_axis(xc, zc, regs[CFG_FOCAL][31:0], regs[CFG_PRINC][31:0],
                      regs[CFG_WINDOW][11:0], regs[CFG_WINDOW][23:12], pix.col))
            return;
        if (!map_axis(yc, zc, regs[CFG_FOCAL][63:32], regs[CFG_PRINC][63:32],
                      regs[CFG_WINDOW][35:24], regs[CFG_WINDOW][47:36], pix.row))
            return;
        pending_pixels.insert(pending_pixels.size(), pix);
    endfunction

    function void check_pixel(logic [PIX_W-1:0] col, logic [PIX_W-1:0] row);
        t_pixel exp_pix;
        pixels_seen++;
        if (pending_pixels.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected pixel col=%0d row=%0d", col, row);
            return;
        end
        exp_pix = pending_pixels.pop_front();
        if (exp_pix.col !== col || exp_pix.row !== row) begin
            mismatches++;
            if (mismatches <= 10)
                $display("pixel mismatch: expected col=%0d row=%0d, got col=%0d row=%0d",
                         exp_pix.col, exp_pix.row, col, row);
        end
    endfunction
endclass

module testbench;
    localparam int LIMIT_CYCLES = 600000;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;
    localparam logic [17:0] ONE = 18'h10000;   // 1.0 in Q2.16
    localparam logic [17:0] NEG_ONE = 18'h30000;

    logic                        i_clk;
    logic                        i_rst_n;
    logic                        i_cfg_we;
    logic [CFG_IDX_W-1:0]        i_cfg_idx;
    logic [CFG_W-1:0]            i_cfg_data;
    logic                        i_valid;
    logic                        o_stall;
    logic signed [23:0]          i_world_x, i_world_y, i_world_z;
    logic                        o_valid;
    logic                        i_stall;
    logic [PIX_W-1:0]            o_pixel_col, o_pixel_row;

    pixel_scoreboard sb;
    bit   send_idle;      // sender draws random gaps
    bit   recv_idle;      // receiver draws random stalls
    int   hold_cycles;    // long receiver hold-off, counted down by the receiver
    int   cycle_count;

    point_to_pixel_projection_window_top #(.COORD_BITS(24)) DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .i_valid(i_valid), .o_stall(o_stall),
        .i_world_x(i_world_x), .i_world_y(i_world_y), .i_world_z(i_world_z),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_pixel_col(o_pixel_col), .o_pixel_row(o_pixel_row)
    );

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    // Abort on a hang.
    initial begin
        cycle_count = 0;
        forever begin
            @(posedge i_clk);
            cycle_count++;
            if (cycle_count > LIMIT_CYCLES) begin
                $display("timeout after %0d cycles", cycle_count);
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    // Result side: check on accepted pixels, hold off as told, else draw stalls.
    initial begin
        int stall_left;
        stall_left = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && !i_stall) begin
                sb.check_pixel(o_pixel_col, o_pixel_row);
                stall_left = recv_idle ? $urandom_range(0, 14) : 0;
            end
            @(negedge i_clk);
            if (hold_cycles > 0) begin
                hold_cycles--;
                i_stall = 1'b1;
            end else if (stall_left > 0) begin
                stall_left--;
                i_stall = 1'b1;
            end else begin
                i_stall = 1'b0;
            end
        end
    end

    // Write one register; keep the mirror in step.
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = val;
        sb.write_reg(idx, val);
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    task automatic write_matrix(logic [53:0] rx, logic [53:0] ry, logic [53:0] rz);
        // Upper bits are junk; the block must mask them.
        write_reg(CFG_ROT_X, {10'($urandom), rx});
        write_reg(CFG_ROT_Y, {10'($urandom), ry});
        write_reg(CFG_ROT_Z, {10'($urandom), rz});
    endtask

    task automatic write_optics(logic [31:0] fx, logic [31:0] fy, logic [31:0] cx,
                                logic [31:0] cy, logic [11:0] l, logic [11:0] r,
                                logic [11:0] t, logic [11:0] b);
        write_reg(CFG_FOCAL, {fy, fx});
        write_reg(CFG_PRINC, {cy, cx});
        write_reg(CFG_WINDOW, {16'($urandom), b, t, r, l});
    endtask

    // Offer one request and hold it until taken.
    task automatic send_point(logic signed [23:0] x, logic signed [23:0] y,
                              logic signed [23:0] z);
        int gap;
        gap = send_idle ? $urandom_range(0, 14) : 0;
        if (gap > 0) begin
            i_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid   = 1'b1;
        i_world_x = x;
        i_world_y = y;
        i_world_z = z;
        do @(posedge i_clk); while (o_stall);
        sb.note_point(x, y, z);
        @(negedge i_clk);
        i_valid = 1'b0;
    endtask

    // Mostly points in front of the camera within about the field of view.
    task automatic send_random(int count);
        int z, lim;
        repeat (count) begin
            if ($urandom_range(0, 4) == 0) begin
                send_point(24'($urandom), 24'($urandom), 24'($urandom));
            end else begin
                z   = $urandom_range(1, 8388607);
                lim = z / 5 * 3;
                send_point(24'($signed($urandom_range(0, 2 * lim)) - lim),
                           24'($signed($urandom_range(0, 2 * lim)) - lim),
                           24'(z));
            end
            // Toggle idling now and then so stretches of back-to-back traffic occur.
            if ($urandom_range(0, 63) == 0) send_idle = !send_idle;
            if ($urandom_range(0, 63) == 0) recv_idle = !recv_idle;
        end
    endtask

    // Pause until every pixel is out, then let dropped points clear the pipe.
    task automatic drain();
        while (sb.pending_pixels.size() != 0) @(negedge i_clk);
        repeat (40) @(negedge i_clk);
    endtask

    initial begin
        sb          = new();
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_idx   = '0;
        i_cfg_data  = '0;
        i_valid     = 1'b0;
        i_world_x   = '0;
        i_world_y   = '0;
        i_world_z   = '0;
        i_stall     = 1'b0;
        hold_cycles = 0;
        send_idle   = 1'b1;
        recv_idle   = 1'b1;
        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Reset config: zero matrix, every depth is zero, nothing comes out.
        send_point(24'sd1000, 24'sd1000, 24'sd1000);
        send_point(-24'sd8388608, 24'sd8388607, 24'sd5);
        drain();

        // Identity camera at origin, 640x480 window with fx=fy=500.
        write_matrix({18'd0, 18'd0, ONE}, {18'd0, ONE, 18'd0}, {ONE, 18'd0, 18'd0});
        write_reg(CFG_CAM, {1'b1, 63'd0});
        write_optics(32'd500 << 16, 32'd500 << 16, 32'd320 << 16, 32'd240 << 16,
                     12'd0, 12'd640, 12'd0, 12'd480);
        write_reg(CFG_UNUSED, 64'hDEAD_BEEF_0123_4567);   // ignored index
        send_point(24'sd0, 24'sd0, 24'sd1000);           // principal point
        send_point(24'sd0, 24'sd0, 24'sd0);              // zero depth
        send_point(24'sd0, 24'sd0, -24'sd1000);          // behind camera
        send_point(24'sd1, 24'sd1, 24'sd1000);           // half pixel: tie to even, down
        send_point(24'sd3, 24'sd3, 24'sd1000);           // half pixel: tie to even, up
        send_point(24'sd3196, 24'sd2396, 24'sd5000);     // rounds onto right/bottom bound
        send_point(-24'sd3196, -24'sd2396, 24'sd5000);   // rounds onto left/top bound
        send_point(24'sd640, 24'sd0, 24'sd1000);         // exactly on right bound
        send_point(-24'sd640, 24'sd0, 24'sd1000);        // exactly on left bound
        send_point(24'sd0, 24'sd480, 24'sd1000);         // exactly on bottom bound
        send_point(24'sd8388607, 24'sd8388607, 24'sd8388607);
        send_point(-24'sd8388608, -24'sd8388608, 24'sd8388607);
        send_point(24'sd0, 24'sd0, -24'sd8388608);
        send_point(24'sd1, -24'sd1, 24'sd1);
        send_random(480);
        drain();

        // Rotated and offset camera, fractional intrinsics.
        write_matrix({18'd0, NEG_ONE, 18'd0}, {18'h0C000, 18'd0, 18'd0},
                     {18'd0, 18'd0, 18'h1FFFF});
        write_reg(CFG_CAM, {21'h1FFF00, 21'h000400, 21'h0FFFFF});
        write_optics(32'h0228_8DE0, 32'h02AA_0CA8, 32'h00EE_C500, 32'h01F4_0000,
                     12'd100, 12'd1000, 12'd200, 12'd900);
        send_random(300);
        drain();

        // Zero focal length: every visible point lands on the principal point.
        write_matrix({18'd0, 18'd0, ONE}, {18'd0, ONE, 18'd0}, {ONE, 18'd0, 18'd0});
        write_reg(CFG_CAM, 64'd0);
        write_optics(32'd0, 32'd0, 32'h0064_8000, 32'h00C8_8000,
                     12'd0, 12'd4095, 12'd0, 12'd4095);
        send_random(100);
        drain();

        // Extremes: largest coefficients, camera corners, maximal focal lengths.
        write_matrix({18'h20000, 18'h1FFFF, 18'h20000}, {18'h1FFFF, 18'h20000, 18'h1FFFF},
                     {18'h1FFFF, 18'h1FFFF, 18'h1FFFF});
        write_reg(CFG_CAM, {21'h100000, 21'h0FFFFF, 21'h100000});
        write_optics(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0800_0000, 32'h0800_0000,
                     12'd0, 12'd4095, 12'd0, 12'd4095);
        send_random(150);
        drain();

        // Back-pressure: the receiver holds off while the sender streams.
        write_matrix({18'd0, 18'd0, ONE}, {18'd0, ONE, 18'd0}, {ONE, 18'd0, 18'd0});
        write_optics(32'd500 << 16, 32'd500 << 16, 32'hFFFF_FFFF, 32'd0,
                     12'd4094, 12'd4095, 12'd0, 12'd1);
        write_optics(32'd500 << 16, 32'd500 << 16, 32'd320 << 16, 32'd240 << 16,
                     12'd0, 12'd640, 12'd0, 12'd480);
        send_idle   = 1'b0;
        hold_cycles = 400;
        send_random(300);
        send_idle = 1'b1;
        drain();

        // Random camera, random optics, random window.
        write_matrix(54'($urandom) ^ {22'($urandom), 32'd0},
                     54'($urandom) ^ {22'($urandom), 32'd0},
                     {ONE, 18'($urandom) & 18'h07FFF, 18'($urandom) & 18'h07FFF});
        write_reg(CFG_CAM, {$urandom, $urandom});
        write_optics($urandom_range(0, 32'h03FF_FFFF), $urandom_range(0, 32'h03FF_FFFF),
                     $urandom_range(0, 32'h07FF_FFFF), $urandom_range(0, 32'h07FF_FFFF),
                     12'($urandom_range(0, 1000)), 12'($urandom_range(1000, 4095)),
                     12'($urandom_range(0, 1000)), 12'($urandom_range(1000, 4095)));
        send_random(200);
        drain();

        // Empty window: nothing may come out.
        write_optics(32'd500 << 16, 32'd500 << 16, 32'd320 << 16, 32'd240 << 16,
                     12'd640, 12'd0, 12'd0, 12'd480);
        send_random(50);
        drain();

        $display("covered %0d points over eight register settings, %0d pixels checked",
                 sb.points_seen, sb.pixels_seen);
        $display("mismatches: %0d, leftover expected pixels: %0d",
                 sb.mismatches, sb.pending_pixels.size());
        if (sb.mismatches == 0 && sb.pending_pixels.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule
